// ===== sv/hill_cipher_block_unit_defines.svh =====
// assertion macros for the hill cipher block checker
`ifndef HILL_CIPHER_BLOCK_UNIT_DEFINES_SVH
`define HILL_CIPHER_BLOCK_UNIT_DEFINES_SVH

// clocked check, off while reset is low
`define HCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define HCB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hcb_pkg.sv =====
// shared types, constants and helpers of the hill cipher block
package hcb_pkg;

  localparam int MAX_BLOCK = 4;
  localparam int IDX_W     = $clog2(MAX_BLOCK);
  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int DIGIT_W   = 5;
  localparam int KEY_W     = 5;
  localparam int LETTER_W  = 7;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int MOD_W     = 10;

  localparam logic [LETTER_W-1:0] LETTER_A   = 7'd65;
  localparam logic [MOD_W-1:0]    MODULUS    = 10'd26;
  localparam logic [MOD_W-1:0]    LETTER_OFS = 10'd13;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_3  = 3'd4;

  typedef logic [DIGIT_W-1:0] hcb_digit_t;
  typedef logic [3:0][KEY_W-1:0] hcb_key_row_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_COMPUTE,
    ST_LOAD,
    ST_EMIT
  } hcb_state_t;

  typedef struct packed {
    logic en;
    logic first;
  } hcb_lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hcb_out_stat_t;

  // x mod 26 for x up to 840: reciprocal estimate, one correction
  function automatic hcb_digit_t mod26(input logic [MOD_W-1:0] x);
    logic [15:0]      prod;
    logic [4:0]       q;
    logic [MOD_W-1:0] r;
    prod = x * 16'd78;
    q    = prod[15:11];
    r    = x - MOD_W'(q * MODULUS);
    if (r >= MODULUS) begin
      r = r - MODULUS;
    end
    return r[DIGIT_W-1:0];
  endfunction

  // key entry reduced mod 26
  function automatic hcb_digit_t key_fold(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    r = (k >= KEY_W'(26)) ? k - KEY_W'(26) : k;
    return r;
  endfunction

endpackage

// ===== sv/hcb_mac_lane.sv =====
// one row lane: serial mod-26 multiply-accumulate over the block digits
module hcb_mac_lane (
  input  logic                  clk,
  input  hcb_pkg::hcb_lane_ctl_t ctl_i,
  input  hcb_pkg::hcb_digit_t   key_i,
  input  hcb_pkg::hcb_digit_t   digit_i,
  output hcb_pkg::hcb_digit_t   acc_o
);
  import hcb_pkg::*;

  hcb_digit_t       acc_r;
  hcb_digit_t       acc_nxt;
  logic [MOD_W-1:0] prod;
  logic [MOD_W-1:0] sum;

  always_comb begin
    prod = MOD_W'(key_i) * MOD_W'(digit_i);
    sum  = prod + (ctl_i.first ? '0 : MOD_W'(acc_r));
    acc_nxt = ctl_i.en ? mod26(sum) : acc_r;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_o = acc_r;

endmodule

// ===== sv/hcb_out_shift.sv =====
// output digit shift register with the result handshake
module hcb_out_shift (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_i,
  input  logic [hcb_pkg::CNT_W-1:0]     count_i,
  input  hcb_pkg::hcb_digit_t           digits_i [hcb_pkg::MAX_BLOCK],
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [hcb_pkg::LETTER_W-1:0]  out_letter_out,
  output logic                          out_block_last,
  output hcb_pkg::hcb_out_stat_t        stat_o
);
  import hcb_pkg::*;

  hcb_digit_t       d_r   [MAX_BLOCK];
  hcb_digit_t       d_nxt [MAX_BLOCK];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             fire;

  assign out_valid      = (cnt_r != '0);
  assign fire           = out_valid && out_ready;
  assign out_letter_out = LETTER_W'(d_r[0]) + LETTER_A;
  assign out_block_last = (cnt_r == CNT_W'(1));
  assign stat_o.busy    = out_valid;
  assign stat_o.done    = fire && out_block_last;

  always_comb begin
    cnt_nxt = cnt_r;
    for (int k = 0; k < MAX_BLOCK; k++) begin
      d_nxt[k] = d_r[k];
    end
    if (load_i) begin
      cnt_nxt = count_i;
      for (int k = 0; k < MAX_BLOCK; k++) begin
        d_nxt[k] = digits_i[k];
      end
    end else if (fire) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int k = 0; k < MAX_BLOCK - 1; k++) begin
        d_nxt[k] = d_r[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BLOCK; k++) begin
      d_r[k] <= d_nxt[k];
    end
  end

endmodule

// ===== sv/hill_cipher_block_unit.sv =====
// top level of the hill cipher block: collect, serial matrix multiply, emit
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   in_letter_in[6:0]
//   out_     output     out_valid/out_ready out_letter_out[6:0], out_block_last
//   cfg_     input      cfg_we              cfg_index[2:0], cfg_data[19:0]
//
// letters are collected through the in_ handshake; a block of n letters then
// goes through digit-serial multiply-accumulate (one column per cycle in all row
// lanes), a load state and n result transactions.
// reset is synchronous, clears the fill count and the state machine and sets
// the registers to block size 3 and the identity key.
// in_ready is low from block completion until its last result is taken.
module hill_cipher_block_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hcb_pkg::LETTER_W-1:0]     in_letter_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hcb_pkg::LETTER_W-1:0]     out_letter_out,
  output logic                             out_block_last,
  input  logic                             cfg_we,
  input  logic [hcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcb_pkg::CFG_W-1:0]        cfg_data
);
  import hcb_pkg::*;

  hcb_state_t       state_r;
  hcb_state_t       state_nxt;
  logic [2:0]       block_size_r;
  hcb_key_row_t     key_r [MAX_BLOCK];
  hcb_digit_t       buf_r [MAX_BLOCK];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] j_r;

  logic [CNT_W-1:0] act_n;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] slot_cnt;
  logic             in_fire;
  logic             blk_done;
  logic             last_step;
  logic             out_load;
  hcb_lane_ctl_t    lane_ctl;
  hcb_out_stat_t    out_stat;
  hcb_digit_t       lane_acc [MAX_BLOCK];
  hcb_digit_t       in_digit;

  always_comb begin
    if (block_size_r == 3'd0) begin
      act_n = CNT_W'(1);
    end else if (block_size_r > 3'(MAX_BLOCK)) begin
      act_n = CNT_W'(MAX_BLOCK);
    end else begin
      act_n = CNT_W'(block_size_r);
    end
  end

  assign slot      = (fill_r >= CNT_W'(MAX_BLOCK)) ? IDX_W'(MAX_BLOCK - 1) : fill_r[IDX_W-1:0];
  assign slot_cnt  = CNT_W'(slot) + CNT_W'(1);
  assign in_fire   = in_valid && in_ready;
  assign blk_done  = in_fire && (slot_cnt >= act_n);
  assign last_step = (CNT_W'(j_r) == n_r - CNT_W'(1));
  assign in_digit  = mod26(MOD_W'(in_letter_in) + LETTER_OFS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: if (blk_done) state_nxt = ST_COMPUTE;
      ST_COMPUTE: if (last_step) state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = ST_EMIT;
      ST_EMIT:    if (out_stat.done) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready       = 1'b0;
    lane_ctl.en    = 1'b0;
    lane_ctl.first = (j_r == '0);
    out_load       = 1'b0;
    unique case (state_r)
      ST_COLLECT: in_ready = 1'b1;
      ST_COMPUTE: lane_ctl.en = 1'b1;
      ST_LOAD:    out_load = 1'b1;
      ST_EMIT:    ;
      default:    ;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (blk_done) begin
      fill_nxt = '0;
    end else if (in_fire) begin
      fill_nxt = slot_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      fill_r       <= '0;
      j_r          <= '0;
      block_size_r <= 3'd3;
      for (int i = 0; i < MAX_BLOCK; i++) begin
        key_r[i] <= hcb_key_row_t'(CFG_W'(1) << (KEY_W * i));
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (state_r == ST_COMPUTE) begin
        j_r <= last_step ? '0 : j_r + IDX_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BLOCK_SIZE: block_size_r <= cfg_data[2:0];
          REG_KEY_ROW_0:  key_r[0] <= cfg_data;
          REG_KEY_ROW_1:  key_r[1] <= cfg_data;
          REG_KEY_ROW_2:  key_r[2] <= cfg_data;
          REG_KEY_ROW_3:  key_r[3] <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  // block buffer: written by slot, shifted out one digit per compute cycle
  always_ff @(posedge clk) begin
    if (blk_done) begin
      n_r <= act_n;
    end
    if (in_fire) begin
      buf_r[slot] <= in_digit;
    end else if (state_r == ST_COMPUTE) begin
      for (int k = 0; k < MAX_BLOCK - 1; k++) begin
        buf_r[k] <= buf_r[k + 1];
      end
    end
  end

  for (genvar i = 0; i < MAX_BLOCK; i++) begin : g_lane
    hcb_mac_lane u_lane (
      .clk     (clk),
      .ctl_i   (lane_ctl),
      .key_i   (key_fold(key_r[i][j_r])),
      .digit_i (buf_r[0]),
      .acc_o   (lane_acc[i])
    );
  end

  hcb_out_shift u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (out_load),
    .count_i        (n_r),
    .digits_i       (lane_acc),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_letter_out (out_letter_out),
    .out_block_last (out_block_last),
    .stat_o         (out_stat)
  );

endmodule

// ===== sv/hcb_checker.sv =====
// port-level checks of the hill cipher block, bound to the top level
`include "hill_cipher_block_unit_defines.svh"

module hcb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_letter_out,
  input logic       out_block_last
);

  `HCB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_letter_out) && $stable(out_block_last), "stalled result changed")
  `HCB_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while results pending")
  `HCB_ASSERT(a_letter_range, out_valid |-> (out_letter_out >= 7'd65) && (out_letter_out <= 7'd90), "result letter out of range")
  `HCB_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind hill_cipher_block_unit hcb_checker u_hcb_checker (.*);
